>>> sv/msas_pkg.sv
package msas_pkg;

   localparam int ACC_BITS   = 28;
   localparam int COUNT_BITS = 16;
   localparam int POT_W      = 2;
   localparam int PTOT_W     = 3;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int CNT_W      = 32;
   localparam int DIV_STEPS  = ACC_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [CNT_W-1:0]      SAMPLES_PER_WORD = CNT_W'(3);
   localparam logic [PTOT_W-1:0]     POT_TOTAL_RESET  = PTOT_W'(1);
   localparam logic [COUNT_BITS-1:0] SETTLE_RESET     = COUNT_BITS'(33);
   localparam logic [COUNT_BITS-1:0] AVERAGE_RESET    = COUNT_BITS'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCAN_ENABLE = 8'd0,
      CSR_POT_TOTAL   = 8'd1,
      CSR_SETTLE      = 8'd2,
      CSR_AVERAGE     = 8'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic step;
      logic cfg_write;
      logic div_step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic avg_done;
   } status_type;

endpackage

>>> sv/muxed_pot_settle_average_scanner_unit.sv
// An accepted word is registered into the datapath state; if it completes an average,
// the 28-step restoring divider (one quotient bit a cycle) runs before publishing.
// One word at a time: req_stall stays high until the result word is published, and
// the output register holds the result while rsp_stall is high.
// Reset (synchronous, active high) restores register defaults, pot 0 settling, counters zero.
module muxed_pot_settle_average_scanner_unit #(
   parameter int MAX_POTS    = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [SAMPLE_BITS-1:0]          req_pot_raw,
   input  logic [SAMPLE_BITS-1:0]          req_in1_raw,
   input  logic [SAMPLE_BITS-1:0]          req_in2_raw,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [SAMPLE_BITS-1:0]          rsp_in1_value,
   output logic [SAMPLE_BITS-1:0]          rsp_in2_value,
   output logic [msas_pkg::POT_W-1:0]      rsp_mux_select,
   output logic                            rsp_pot_valid,
   output logic [msas_pkg::POT_W-1:0]      rsp_pot_index,
   output logic [SAMPLE_BITS-1:0]          rsp_pot_average,
   output logic [msas_pkg::CNT_W-1:0]      rsp_sample_count,
   output logic [msas_pkg::CNT_W-1:0]      rsp_switch_count,
   output logic [msas_pkg::CNT_W-1:0]      rsp_discard_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [msas_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [msas_pkg::CSR_DATA_W-1:0] csr_data
);
   import msas_pkg::*;

   cmd_type    cmd;
   status_type status;

   msas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   msas_datapath #(
      .MAX_POTS    (MAX_POTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .pot_raw       (req_pot_raw),
      .in1_raw       (req_in1_raw),
      .in2_raw       (req_in2_raw),
      .in1_value     (rsp_in1_value),
      .in2_value     (rsp_in2_value),
      .mux_select    (rsp_mux_select),
      .pot_valid     (rsp_pot_valid),
      .pot_index     (rsp_pot_index),
      .pot_average   (rsp_pot_average),
      .sample_count  (rsp_sample_count),
      .switch_count  (rsp_switch_count),
      .discard_count (rsp_discard_count)
   );

endmodule

>>> sv/msas_ctrl.sv
module msas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  msas_pkg::status_type status,
   output msas_pkg::cmd_type    cmd
);
   import msas_pkg::*;

   state_type             state_ff, state_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  accept;

   assign accept = (state_ff == ST_IDLE) && req_valid;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            div_cnt_in = DIV_CNT_W'(DIV_STEPS - 1);
            if (accept) begin
               state_in = status.avg_done ? ST_DIV : ST_PUBLISH;
            end
         end
         ST_DIV: begin
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (!out_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.step      = accept;
      cmd.cfg_write = csr_valid && csr_ready;
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.publish   = (state_ff == ST_PUBLISH) && (!out_valid_ff || !rsp_stall);
      req_stall     = (state_ff != ST_IDLE);
      csr_ready     = (state_ff == ST_IDLE) && !req_valid;
      rsp_valid     = out_valid_ff;
      out_valid_in  = cmd.publish ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> sv/msas_datapath.sv
module msas_datapath #(
   parameter int MAX_POTS    = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  msas_pkg::cmd_type                     cmd,
   output msas_pkg::status_type                  status,
   input  logic [msas_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [msas_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic [SAMPLE_BITS-1:0]                pot_raw,
   input  logic [SAMPLE_BITS-1:0]                in1_raw,
   input  logic [SAMPLE_BITS-1:0]                in2_raw,
   output logic [SAMPLE_BITS-1:0]                in1_value,
   output logic [SAMPLE_BITS-1:0]                in2_value,
   output logic [msas_pkg::POT_W-1:0]            mux_select,
   output logic                                  pot_valid,
   output logic [msas_pkg::POT_W-1:0]            pot_index,
   output logic [SAMPLE_BITS-1:0]                pot_average,
   output logic [msas_pkg::CNT_W-1:0]            sample_count,
   output logic [msas_pkg::CNT_W-1:0]            switch_count,
   output logic [msas_pkg::CNT_W-1:0]            discard_count
);
   import msas_pkg::*;

   logic                   scan_en_ff, scan_en_in;
   logic [PTOT_W-1:0]      pot_total_ff, pot_total_in;
   logic [COUNT_BITS-1:0]  settle_cfg_ff, settle_cfg_in;
   logic [COUNT_BITS-1:0]  avg_cfg_ff, avg_cfg_in;

   logic [POT_W-1:0]       cur_pot_ff, cur_pot_in;
   logic                   phase_ff, phase_in;
   logic [COUNT_BITS-1:0]  settle_left_ff, settle_left_in;
   logic [COUNT_BITS-1:0]  avg_left_ff, avg_left_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [SAMPLE_BITS-1:0] in1_ff, in1_in;
   logic [SAMPLE_BITS-1:0] in2_ff, in2_in;
   logic [CNT_W-1:0]       samples_ff, samples_in;
   logic [CNT_W-1:0]       switches_ff, switches_in;
   logic [CNT_W-1:0]       discards_ff, discards_in;
   logic                   done_ff, done_in;
   logic [POT_W-1:0]       done_idx_ff, done_idx_in;
   logic [ACC_BITS-1:0]    quo_ff, quo_in;
   logic [COUNT_BITS-1:0]  rem_ff, rem_in;

   logic [SAMPLE_BITS-1:0] o_in1_ff, o_in2_ff, o_avg_ff;
   logic [POT_W-1:0]       o_mux_ff, o_idx_ff;
   logic                   o_valid_ff;
   logic [CNT_W-1:0]       o_samples_ff, o_switches_ff, o_discards_ff;

   logic [PTOT_W-1:0]      eff_pots;
   logic [COUNT_BITS-1:0]  eff_avg;
   logic                   restart;
   logic [COUNT_BITS-1:0]  settle_dec, avg_dec;
   logic [ACC_BITS-1:0]    acc_sum;
   logic [PTOT_W-1:0]      pot_inc;
   logic [COUNT_BITS:0]    rem_sh, rem_diff;

   always_comb begin
      if (pot_total_ff == '0) begin
         eff_pots = PTOT_W'(1);
      end else if (pot_total_ff > PTOT_W'(MAX_POTS)) begin
         eff_pots = PTOT_W'(MAX_POTS);
      end else begin
         eff_pots = pot_total_ff;
      end
      eff_avg    = (avg_cfg_ff == '0) ? COUNT_BITS'(1) : avg_cfg_ff;
      settle_dec = (settle_left_ff != '0) ? settle_left_ff - COUNT_BITS'(1) : settle_left_ff;
      avg_dec    = (avg_left_ff != '0) ? avg_left_ff - COUNT_BITS'(1) : avg_left_ff;
      acc_sum    = acc_ff + ACC_BITS'(pot_raw);
      pot_inc    = {1'b0, cur_pot_ff} + PTOT_W'(1);
      rem_sh     = {rem_ff, quo_ff[ACC_BITS-1]};
      rem_diff   = rem_sh - {1'b0, eff_avg};
      status.avg_done = scan_en_ff && phase_ff && (avg_dec == '0);
   end

   always_comb begin
      scan_en_in     = scan_en_ff;
      pot_total_in   = pot_total_ff;
      settle_cfg_in  = settle_cfg_ff;
      avg_cfg_in     = avg_cfg_ff;
      cur_pot_in     = cur_pot_ff;
      phase_in       = phase_ff;
      settle_left_in = settle_left_ff;
      avg_left_in    = avg_left_ff;
      acc_in         = acc_ff;
      in1_in         = in1_ff;
      in2_in         = in2_ff;
      samples_in     = samples_ff;
      switches_in    = switches_ff;
      discards_in    = discards_ff;
      done_in        = done_ff;
      done_idx_in    = done_idx_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      restart        = 1'b0;

      if (cmd.cfg_write) begin
         case (csr_index)
            CSR_SCAN_ENABLE: begin
               scan_en_in = csr_data[0];
               restart    = 1'b1;
            end
            CSR_POT_TOTAL: begin
               pot_total_in = csr_data[PTOT_W-1:0];
               restart      = 1'b1;
            end
            CSR_SETTLE: begin
               settle_cfg_in = csr_data[COUNT_BITS-1:0];
               restart       = 1'b1;
            end
            CSR_AVERAGE: begin
               avg_cfg_in = csr_data[COUNT_BITS-1:0];
               restart    = 1'b1;
            end
            default: restart = 1'b0;
         endcase
         if (restart) begin
            cur_pot_in     = '0;
            phase_in       = 1'b0;
            settle_left_in = settle_cfg_in;
            avg_left_in    = '0;
            acc_in         = '0;
         end
      end else if (cmd.step) begin
         in1_in     = in1_raw;
         in2_in     = in2_raw;
         samples_in = samples_ff + SAMPLES_PER_WORD;
         done_in    = 1'b0;
         if (scan_en_ff) begin
            if (!phase_ff) begin
               discards_in    = discards_ff + CNT_W'(1);
               settle_left_in = settle_dec;
               if (settle_dec == '0) begin
                  phase_in    = 1'b1;
                  avg_left_in = eff_avg;
                  acc_in      = '0;
               end
            end else begin
               acc_in      = acc_sum;
               avg_left_in = avg_dec;
               if (avg_dec == '0) begin
                  done_in        = 1'b1;
                  done_idx_in    = cur_pot_ff;
                  quo_in         = acc_sum;
                  rem_in         = '0;
                  cur_pot_in     = (pot_inc >= eff_pots) ? '0 : pot_inc[POT_W-1:0];
                  switches_in    = switches_ff + CNT_W'(1);
                  phase_in       = 1'b0;
                  settle_left_in = settle_cfg_ff;
               end
            end
         end
      end

      if (cmd.div_step) begin
         if (!rem_diff[COUNT_BITS]) begin
            rem_in = rem_diff[COUNT_BITS-1:0];
            quo_in = {quo_ff[ACC_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[COUNT_BITS-1:0];
            quo_in = {quo_ff[ACC_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_en_ff     <= 1'b0;
         pot_total_ff   <= POT_TOTAL_RESET;
         settle_cfg_ff  <= SETTLE_RESET;
         avg_cfg_ff     <= AVERAGE_RESET;
         cur_pot_ff     <= '0;
         phase_ff       <= 1'b0;
         settle_left_ff <= SETTLE_RESET;
         avg_left_ff    <= '0;
         acc_ff         <= '0;
         in1_ff         <= '0;
         in2_ff         <= '0;
         samples_ff     <= '0;
         switches_ff    <= '0;
         discards_ff    <= '0;
         done_ff        <= 1'b0;
      end else begin
         scan_en_ff     <= scan_en_in;
         pot_total_ff   <= pot_total_in;
         settle_cfg_ff  <= settle_cfg_in;
         avg_cfg_ff     <= avg_cfg_in;
         cur_pot_ff     <= cur_pot_in;
         phase_ff       <= phase_in;
         settle_left_ff <= settle_left_in;
         avg_left_ff    <= avg_left_in;
         acc_ff         <= acc_in;
         in1_ff         <= in1_in;
         in2_ff         <= in2_in;
         samples_ff     <= samples_in;
         switches_ff    <= switches_in;
         discards_ff    <= discards_in;
         done_ff        <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      done_idx_ff <= done_idx_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
   end

   // output word register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         o_in1_ff      <= in1_ff;
         o_in2_ff      <= in2_ff;
         o_mux_ff      <= cur_pot_ff;
         o_valid_ff    <= done_ff;
         o_idx_ff      <= done_ff ? done_idx_ff : '0;
         o_avg_ff      <= done_ff ? quo_ff[SAMPLE_BITS-1:0] : '0;
         o_samples_ff  <= samples_ff;
         o_switches_ff <= switches_ff;
         o_discards_ff <= discards_ff;
      end
   end

   assign in1_value     = o_in1_ff;
   assign in2_value     = o_in2_ff;
   assign mux_select    = o_mux_ff;
   assign pot_valid     = o_valid_ff;
   assign pot_index     = o_idx_ff;
   assign pot_average   = o_avg_ff;
   assign sample_count  = o_samples_ff;
   assign switch_count  = o_switches_ff;
   assign discard_count = o_discards_ff;

endmodule

>>> dv/muxed_pot_settle_average_scanner_unit_tb.sv
`timescale 1ns / 100ps

module muxed_pot_settle_average_scanner_unit_tb;
   import msas_pkg::*;

   localparam int SB           = 12;
   localparam int NPOTS        = 4;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 64;
   localparam int RAND_PHASES  = 13;
   localparam int PHASE_WORDS  = 110;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 8'hFF;
   localparam logic [SB-1:0]        SAMPLE_MAX   = '1;

   typedef struct {
      logic [SB-1:0]    in1;
      logic [SB-1:0]    in2;
      logic [POT_W-1:0] mux;
      logic             pot_valid;
      logic [POT_W-1:0] pot_index;
      logic [SB-1:0]    pot_average;
      logic [CNT_W-1:0] sample_count;
      logic [CNT_W-1:0] switch_count;
      logic [CNT_W-1:0] discard_count;
   } scan_word_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [SB-1:0]         req_pot_raw;
   logic [SB-1:0]         req_in1_raw;
   logic [SB-1:0]         req_in2_raw;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [SB-1:0]         rsp_in1_value;
   logic [SB-1:0]         rsp_in2_value;
   logic [POT_W-1:0]      rsp_mux_select;
   logic                  rsp_pot_valid;
   logic [POT_W-1:0]      rsp_pot_index;
   logic [SB-1:0]         rsp_pot_average;
   logic [CNT_W-1:0]      rsp_sample_count;
   logic [CNT_W-1:0]      rsp_switch_count;
   logic [CNT_W-1:0]      rsp_discard_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // scanner model
   logic                  en_r;
   logic [PTOT_W-1:0]     pots_r;
   logic [COUNT_BITS-1:0] settle_r;
   logic [COUNT_BITS-1:0] average_r;
   logic [POT_W-1:0]      cur_pot;
   logic                  averaging;
   logic [COUNT_BITS-1:0] settle_left;
   logic [COUNT_BITS-1:0] average_left;
   logic [ACC_BITS-1:0]   acc;
   logic [SB-1:0]         in1_last;
   logic [SB-1:0]         in2_last;
   logic [CNT_W-1:0]      samples;
   logic [CNT_W-1:0]      switches;
   logic [CNT_W-1:0]      discards;

   scan_word_t  pending_scan[$];
   scan_word_t  due;
   int          fail_count;
   int unsigned cycle_count;
   bit          hold_req;

   muxed_pot_settle_average_scanner_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pot_raw       (req_pot_raw),
      .req_in1_raw       (req_in1_raw),
      .req_in2_raw       (req_in2_raw),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_in1_value     (rsp_in1_value),
      .rsp_in2_value     (rsp_in2_value),
      .rsp_mux_select    (rsp_mux_select),
      .rsp_pot_valid     (rsp_pot_valid),
      .rsp_pot_index     (rsp_pot_index),
      .rsp_pot_average   (rsp_pot_average),
      .rsp_sample_count  (rsp_sample_count),
      .rsp_switch_count  (rsp_switch_count),
      .rsp_discard_count (rsp_discard_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("muxed_pot_settle_average_scanner_unit regression: fail");
         $finish;
      end
   end

   function automatic int unsigned pots_in_use();
      if (pots_r == 0) return 1;
      if (pots_r > NPOTS) return NPOTS;
      return pots_r;
   endfunction

   function automatic logic [COUNT_BITS-1:0] average_in_use();
      return (average_r == 0) ? COUNT_BITS'(1) : average_r;
   endfunction

   task automatic restart_scan();
      cur_pot      = '0;
      averaging    = 1'b0;
      settle_left  = settle_r;
      average_left = '0;
      acc          = '0;
   endtask

   task automatic apply_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      bit known;
      known = 1'b1;
      case (idx)
         CSR_SCAN_ENABLE: en_r      = data[0];
         CSR_POT_TOTAL:   pots_r    = data[PTOT_W-1:0];
         CSR_SETTLE:      settle_r  = data;
         CSR_AVERAGE:     average_r = data;
         default:         known     = 1'b0;
      endcase
      if (known) restart_scan();
   endtask

   function automatic scan_word_t scan_frame(input logic [SB-1:0] pot,
                                             input logic [SB-1:0] in1,
                                             input logic [SB-1:0] in2);
      scan_word_t w;
      w.pot_valid   = 1'b0;
      w.pot_index   = '0;
      w.pot_average = '0;
      in1_last = in1;
      in2_last = in2;
      samples  = samples + SAMPLES_PER_WORD;
      if (en_r) begin
         if (!averaging) begin
            discards = discards + 1;
            if (settle_left != 0) settle_left = settle_left - 1;
            if (settle_left == 0) begin
               averaging    = 1'b1;
               average_left = average_in_use();
               acc          = '0;
            end
         end else begin
            acc = acc + pot;
            if (average_left != 0) average_left = average_left - 1;
            if (average_left == 0) begin
               w.pot_average = SB'(acc / average_in_use());
               w.pot_index   = cur_pot;
               w.pot_valid   = 1'b1;
               cur_pot       = POT_W'((cur_pot + 1) % pots_in_use());
               switches      = switches + 1;
               averaging     = 1'b0;
               settle_left   = settle_r;
            end
         end
      end
      w.in1           = in1_last;
      w.in2           = in2_last;
      w.mux           = cur_pot;
      w.sample_count  = samples;
      w.switch_count  = switches;
      w.discard_count = discards;
      return w;
   endfunction

   task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scan.size() == 0) begin
            fail_count++;
            $error("result word with none outstanding");
         end else begin
            due = pending_scan.pop_front();
            check_field("in1_value", due.in1, rsp_in1_value);
            check_field("in2_value", due.in2, rsp_in2_value);
            check_field("mux_select", due.mux, rsp_mux_select);
            check_field("pot_valid", due.pot_valid, rsp_pot_valid);
            check_field("pot_index", due.pot_index, rsp_pot_index);
            check_field("pot_average", due.pot_average, rsp_pot_average);
            check_field("sample_count", due.sample_count, rsp_sample_count);
            check_field("switch_count", due.switch_count, rsp_switch_count);
            check_field("discard_count", due.discard_count, rsp_discard_count);
         end
      end
   end

   // result side back-pressure
   initial begin
      int r;
      int len;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
               rsp_stall <= 1'b1;
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                 : $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b0;
               len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 8);
            end
            repeat (len) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SB-1:0] rand_sample();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return SAMPLE_MAX;
      return SB'($urandom);
   endfunction

   task automatic send_frame(input logic [SB-1:0] pot, input logic [SB-1:0] in1,
                             input logic [SB-1:0] in2);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_pot_raw <= pot;
      req_in1_raw <= in1;
      req_in2_raw <= in2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_scan.push_back(scan_frame(pot, in1, in2));
   endtask

   task automatic send_random(input int count);
      repeat (count) send_frame(rand_sample(), rand_sample(), rand_sample());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_scan.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, data);
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic program_scanner(input bit en, input logic [PTOT_W-1:0] pots,
                                  input logic [COUNT_BITS-1:0] settle,
                                  input logic [COUNT_BITS-1:0] average);
      logic [CSR_DATA_W-1:0] noise;
      drain();
      noise = CSR_DATA_W'($urandom);
      csr_write(CSR_SCAN_ENABLE, {noise[CSR_DATA_W-1:1], en}, 1'b0);
      noise = CSR_DATA_W'($urandom);
      csr_write(CSR_POT_TOTAL, {noise[CSR_DATA_W-1:PTOT_W], pots}, 1'b0);
      csr_write(CSR_SETTLE, settle, 1'b0);
      csr_write(CSR_AVERAGE, average, 1'b1);
   endtask

   task automatic test_scan_disabled();
      send_frame('0, '0, '0);
      send_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      send_frame(12'hA5A, 12'h5A5, 12'h3C3);
   endtask

   // zero pot, settle and average counts all fall back to one
   task automatic test_zero_counts();
      program_scanner(1'b1, 3'd0, 16'd0, 16'd0);
      send_frame(SAMPLE_MAX, '0, SAMPLE_MAX);
      send_frame(SAMPLE_MAX, SAMPLE_MAX, '0);
      send_frame('0, 12'h800, 12'h001);
      send_frame(12'h7FF, 12'h001, 12'h800);
   endtask

   // pot count above the maximum, full round through every pot
   task automatic test_pot_wrap();
      program_scanner(1'b1, 3'd7, 16'd1, 16'd2);
      for (int i = 0; i < 12; i++)
         send_frame((i % 2 == 0) ? SAMPLE_MAX : rand_sample(), rand_sample(), rand_sample());
   endtask

   task automatic test_unknown_register();
      send_frame(SAMPLE_MAX, rand_sample(), rand_sample());
      drain();
      csr_write(CSR_SPARE_LO, '1, 1'b0);
      csr_write(CSR_SPARE_HI, '0, 1'b1);
      send_frame(SAMPLE_MAX, rand_sample(), rand_sample());
      send_frame(rand_sample(), rand_sample(), rand_sample());
   endtask

   task automatic test_register_extremes();
      program_scanner(1'b1, 3'd4, 16'hFFFF, 16'hFFFF);
      send_random(3);
      program_scanner(1'b1, 3'd4, 16'd1, 16'hFFFF);
      repeat (3) send_frame(SAMPLE_MAX, rand_sample(), rand_sample());
   endtask

   task automatic test_output_backpressure();
      program_scanner(1'b1, 3'd4, 16'd1, 16'd2);
      hold_req = 1'b1;
      send_random(40);
   endtask

   task automatic test_sender_pause();
      program_scanner(1'b1, 3'd3, 16'd2, 16'd3);
      send_random(30);
      drain();
      send_random(30);
   endtask

   task automatic test_random_scan();
      int r;
      bit en;
      logic [COUNT_BITS-1:0] settle;
      logic [COUNT_BITS-1:0] average;
      for (int p = 0; p < RAND_PHASES; p++) begin
         en = ($urandom_range(0, 5) != 0);
         r  = $urandom_range(0, 9);
         settle  = (r < 7) ? COUNT_BITS'($urandom_range(0, 4)) :
                   (r < 9) ? COUNT_BITS'($urandom_range(5, 40)) : SETTLE_RESET;
         r  = $urandom_range(0, 19);
         average = (r < 14) ? COUNT_BITS'($urandom_range(0, 6)) :
                   (r < 19) ? COUNT_BITS'($urandom_range(7, 40)) :
                              COUNT_BITS'($urandom_range(100, 200));
         program_scanner(en, PTOT_W'($urandom_range(0, 7)), settle, average);
         if ($urandom_range(0, 3) == 0) begin
            send_random(PHASE_WORDS / 2);
            drain();
            csr_write(($urandom_range(0, 1) == 0) ? CSR_SPARE_LO : CSR_SPARE_HI,
                      CSR_DATA_W'($urandom), 1'b1);
            send_random(PHASE_WORDS / 2);
         end else begin
            send_random(PHASE_WORDS);
         end
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_pot_raw <= '0;
      req_in1_raw <= '0;
      req_in2_raw <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_SCAN_ENABLE;
      csr_data    <= '0;
      fail_count = 0;
      hold_req   = 1'b0;
      en_r       = 1'b0;
      pots_r     = POT_TOTAL_RESET;
      settle_r   = SETTLE_RESET;
      average_r  = AVERAGE_RESET;
      in1_last   = '0;
      in2_last   = '0;
      samples    = '0;
      switches   = '0;
      discards   = '0;
      restart_scan();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_scan_disabled();
      test_zero_counts();
      test_pot_wrap();
      test_unknown_register();
      test_register_extremes();
      test_output_backpressure();
      test_sender_pause();
      test_random_scan();

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("muxed_pot_settle_average_scanner_unit regression: pass");
      end else begin
         $display("muxed_pot_settle_average_scanner_unit regression: fail");
      end
      $finish;
   end

endmodule
